[hdl/wuf_pkg.sv]
// shared types and constants for the weighted union-find unit
package wuf_pkg;

    localparam int ELEM_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int COUNT_LIMIT = 2047;
    localparam int RESET_COUNT = 1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_P,
        S_WALK_Q,
        S_SIZE_P,
        S_SIZE_Q,
        S_DONE
    } wuf_state_t;

    typedef struct packed {
        logic              kind;
        logic [ELEM_W-1:0] p;
        logic [ELEM_W-1:0] q;
    } wuf_req_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  root_p;
        logic [ELEM_W-1:0]  root_q;
        logic               same_set;
        logic [COUNT_W-1:0] set_total;
        logic               bad_index;
    } wuf_res_t;

    typedef struct packed {
        logic               busy;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] sets;
    } wuf_stat_t;

endpackage

[hdl/wuf_ram.sv]
// generic single-write, single-read ram with registered read data
module wuf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/wuf_init.sv]
// element count register, set counter and the table clearing sweep
module wuf_init import wuf_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    localparam int AW = $clog2(MAX_ELEMENTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic               dec,
    output wuf_stat_t          stat,
    output logic [AW-1:0]      clr_addr
);

    localparam int CAP_INT = (MAX_ELEMENTS > COUNT_LIMIT) ? COUNT_LIMIT : MAX_ELEMENTS;
    localparam int RST_INT = (RESET_COUNT > MAX_ELEMENTS) ? MAX_ELEMENTS : RESET_COUNT;
    localparam logic [COUNT_W-1:0] CNT_CAP = COUNT_W'(CAP_INT);
    localparam logic [COUNT_W-1:0] RST_CNT = COUNT_W'(RST_INT);
    localparam logic [AW-1:0]      LAST_IDX = AW'(MAX_ELEMENTS - 1);

    logic               busy_reg, busy_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] sets_reg, sets_next;
    logic [COUNT_W-1:0] clamped;
    logic               wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            clamped = COUNT_W'(1);
        end
        else if (cfg_data > CNT_CAP)
        begin
            clamped = CNT_CAP;
        end
        else
        begin
            clamped = cfg_data;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        sets_next  = sets_reg;
        if (wr)
        begin
            // a write restarts the sweep from entry zero
            busy_next  = 1'b1;
            idx_next   = '0;
            count_next = clamped;
            sets_next  = clamped;
        end
        else
        begin
            if (busy_reg)
            begin
                idx_next = idx_reg + AW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    busy_next = 1'b0;
                    idx_next  = '0;
                end
            end
            if (dec && sets_reg != '0)
            begin
                sets_next = sets_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            count_reg <= RST_CNT;
            sets_reg  <= RST_CNT;
        end
        else
        begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            sets_reg  <= sets_next;
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.count = count_reg;
    assign stat.sets  = sets_reg;
    assign clr_addr   = idx_reg;

endmodule

[hdl/wuf_seq.sv]
// request sequencer: two root walks, size compare and link write-back
module wuf_seq import wuf_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024,
    localparam int AW = $clog2(MAX_ELEMENTS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  wuf_req_t           req,
    input  wuf_stat_t          stat,
    output logic               dec,
    output logic [AW-1:0]      par_raddr,
    input  logic [AW-1:0]      par_rdata,
    output logic               par_we,
    output logic [AW-1:0]      par_waddr,
    output logic [AW-1:0]      par_wdata,
    output logic [AW-1:0]      sz_raddr,
    input  logic [COUNT_W-1:0] sz_rdata,
    output logic               sz_we,
    output logic [AW-1:0]      sz_waddr,
    output logic [COUNT_W-1:0] sz_wdata,
    input  logic               out_free,
    output logic               res_valid,
    output wuf_res_t           res
);

    wuf_state_t         state_reg, state_next;
    logic               kind_reg, kind_next;
    logic [ELEM_W-1:0]  q_reg, q_next;
    logic [AW-1:0]      x_reg, x_next;
    logic [AW-1:0]      rp_reg, rp_next;
    logic [AW-1:0]      rq_reg, rq_next;
    logic               same_reg, same_next;
    logic               bad_reg, bad_next;
    logic [COUNT_W-1:0] szp_reg, szp_next;
    logic               is_root;
    logic               bad_req;
    logic [COUNT_W-1:0] sz_sum;

    assign is_root = (par_rdata == x_reg);
    assign bad_req = ({1'b0, req.p} >= stat.count) || ({1'b0, req.q} >= stat.count);
    assign sz_sum  = szp_reg + sz_rdata;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        q_next     = q_reg;
        x_next     = x_reg;
        rp_next    = rp_reg;
        rq_next    = rq_reg;
        same_next  = same_reg;
        bad_next   = bad_reg;
        szp_next   = szp_reg;
        req_ready  = 1'b0;
        dec        = 1'b0;
        par_raddr  = x_reg;
        par_we     = 1'b0;
        par_waddr  = rq_reg;
        par_wdata  = rp_reg;
        sz_raddr   = rp_reg;
        sz_we      = 1'b0;
        sz_waddr   = rp_reg;
        sz_wdata   = sz_sum;
        res_valid  = 1'b0;
        res.root_p    = ELEM_W'(rp_reg);
        res.root_q    = ELEM_W'(rq_reg);
        res.same_set  = same_reg;
        res.set_total = stat.sets;
        res.bad_index = bad_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = !stat.busy;
                par_raddr = AW'(req.p);
                if (req_valid && !stat.busy)
                begin
                    kind_next = req.kind;
                    q_next    = req.q;
                    x_next    = AW'(req.p);
                    bad_next  = bad_req;
                    if (bad_req)
                    begin
                        rp_next    = '0;
                        rq_next    = '0;
                        same_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK_P;
                    end
                end
            end
            S_WALK_P:
            begin
                if (is_root)
                begin
                    rp_next    = x_reg;
                    x_next     = AW'(q_reg);
                    par_raddr  = AW'(q_reg);
                    state_next = S_WALK_Q;
                end
                else
                begin
                    x_next    = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            S_WALK_Q:
            begin
                par_raddr = par_rdata;
                if (is_root)
                begin
                    rq_next   = x_reg;
                    same_next = (x_reg == rp_reg);
                    // size of p's root is fetched while deciding
                    sz_raddr  = rp_reg;
                    if (kind_reg && (x_reg != rp_reg))
                    begin
                        state_next = S_SIZE_P;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    x_next = par_rdata;
                end
            end
            S_SIZE_P:
            begin
                szp_next   = sz_rdata;
                sz_raddr   = rq_reg;
                state_next = S_SIZE_Q;
            end
            S_SIZE_Q:
            begin
                // smaller tree goes under the larger, ties put q's root under p's
                par_we = 1'b1;
                sz_we  = 1'b1;
                dec    = 1'b1;
                if (szp_reg < sz_rdata)
                begin
                    par_waddr = rp_reg;
                    par_wdata = rq_reg;
                    sz_waddr  = rq_reg;
                end
                else
                begin
                    par_waddr = rq_reg;
                    par_wdata = rp_reg;
                    sz_waddr  = rp_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        q_reg    <= q_next;
        x_reg    <= x_next;
        rp_reg   <= rp_next;
        rq_reg   <= rq_next;
        same_reg <= same_next;
        bad_reg  <= bad_next;
        szp_reg  <= szp_next;
    end

endmodule

[hdl/weighted_union_find_unit.sv]
// top level of the weighted union-find unit
// disjoint-set forest, union by size, parent and size tables in two rams.
// s_* channel: one request per transaction, tuser = request kind
// (0 query, 1 union), tdata = element p and element q.
// m_* channel: one result per request, tdata = both roots, same-set flag and
// the set count after the request; tuser flags an index at or beyond the
// element count (roots and flag then read zero, nothing changes).
// cfg channel: writes the element count (0 taken as 1, capped at the lower of
// MAX_ELEMENTS and COUNT_LIMIT) and restarts every set.
// after reset and after each cfg write the tables are swept one entry per
// cycle over all MAX_ELEMENTS entries, with s_tready low.
// a request runs its two root walks, one ram read per tree level, then on
// a real union the size reads and write-back, then the output register;
// tree depth stays at most log2 of the element count.
// one request is in flight at a time; the next is taken while the previous
// result sits in the output register, and a stalled m_tready holds the
// finished result inside until the register frees.
module weighted_union_find_unit import wuf_pkg::*; #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,   // elem_p, elem_q, zero pad
    input  logic               s_tuser,   // req_type
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // root_p, root_q, same_set, set_total
    output logic               m_tuser,   // bad_index
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    wuf_req_t           req;
    wuf_res_t           res;
    wuf_stat_t          stat;
    logic               dec;
    logic               res_valid;
    logic               out_free;
    logic [AW-1:0]      clr_addr;
    logic [AW-1:0]      par_raddr, par_rdata, par_waddr, par_wdata;
    logic               par_we;
    logic [AW-1:0]      sz_raddr, sz_waddr;
    logic [COUNT_W-1:0] sz_rdata, sz_wdata;
    logic               sz_we;
    logic               par_we_m, sz_we_m;
    logic [AW-1:0]      par_waddr_m, par_wdata_m, sz_waddr_m;
    logic [COUNT_W-1:0] sz_wdata_m;

    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic               m_tuser_reg;

    assign req.kind = s_tuser;
    assign req.p    = s_tdata[ELEM_W-1:0];
    assign req.q    = s_tdata[2*ELEM_W-1:ELEM_W];

    wuf_init #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_init (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .dec       (dec),
        .stat      (stat),
        .clr_addr  (clr_addr)
    );

    wuf_seq #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .stat      (stat),
        .dec       (dec),
        .par_raddr (par_raddr),
        .par_rdata (par_rdata),
        .par_we    (par_we),
        .par_waddr (par_waddr),
        .par_wdata (par_wdata),
        .sz_raddr  (sz_raddr),
        .sz_rdata  (sz_rdata),
        .sz_we     (sz_we),
        .sz_waddr  (sz_waddr),
        .sz_wdata  (sz_wdata),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // the clearing sweep owns the write ports while it runs
    assign par_we_m    = stat.busy ? 1'b1 : par_we;
    assign par_waddr_m = stat.busy ? clr_addr : par_waddr;
    assign par_wdata_m = stat.busy ? clr_addr : par_wdata;
    assign sz_we_m     = stat.busy ? 1'b1 : sz_we;
    assign sz_waddr_m  = stat.busy ? clr_addr : sz_waddr;
    assign sz_wdata_m  = stat.busy ? COUNT_W'(1) : sz_wdata;

    wuf_ram #(.WIDTH(AW), .DEPTH(MAX_ELEMENTS)) u_parent_ram (
        .clk   (clk),
        .we    (par_we_m),
        .waddr (par_waddr_m),
        .wdata (par_wdata_m),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    wuf_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_ELEMENTS)) u_size_ram (
        .clk   (clk),
        .we    (sz_we_m),
        .waddr (sz_waddr_m),
        .wdata (sz_wdata_m),
        .raddr (sz_raddr),
        .rdata (sz_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_tdata_reg <= {res.set_total, res.same_set, res.root_q, res.root_p};
            m_tuser_reg <= res.bad_index;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !s_tready)
        else $error("request accepted during table sweep");

    a_sets_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sets <= stat.count)
        else $error("set count above element count");

    a_bad_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[2*ELEM_W:0] == '0))
        else $error("flagged result carries roots");

    a_same_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2*ELEM_W]) |->
        (m_tdata[ELEM_W-1:0] == m_tdata[2*ELEM_W-1:ELEM_W]))
        else $error("same-set result with different roots");

endmodule
